FILE: hw/rtl/triangular_dust_noise_generator_assert.svh
// Assertion macros for the triangular dust noise generator checker.
// Depends on nothing; included by the checker file.
`ifndef TRIANGULAR_DUST_NOISE_GENERATOR_ASSERT_SVH
`define TRIANGULAR_DUST_NOISE_GENERATOR_ASSERT_SVH

// same-cycle implication
`define TDNG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tdng assertion failed");

// next-cycle implication
`define TDNG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tdng assertion failed");

`endif

FILE: hw/rtl/tdng_pkg.sv
// Shared types, constants and functions of the triangular dust noise generator.
// No dependencies.
package tdng_pkg;

    // pop phase codes
    localparam logic [1:0] PH_DRAW = 2'd0;
    localparam logic [1:0] PH_GAP  = 2'd1;
    localparam logic [1:0] PH_UP   = 2'd2;
    localparam logic [1:0] PH_DOWN = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_MEAN_GAP  = 2'd0;
    localparam logic [1:0] CFG_POP_WIDTH = 2'd1;
    localparam logic [1:0] CFG_SYMMETRY  = 2'd2;
    localparam logic [1:0] CFG_SEED      = 2'd3;

    // symmetry codes
    localparam logic [1:0] SYM_NEG  = 2'd1;
    localparam logic [1:0] SYM_BOTH = 2'd2;

    localparam logic [23:0] MEAN_GAP_RESET = 24'd4410;
    localparam logic [31:0] SEED_RESET     = 32'd12345;
    localparam logic [1:0]  SYM_RESET      = 2'd0;

    localparam int          LOG_FRAC = 24;
    localparam logic [31:0] LN2_Q32  = 32'd2977044472;

    // LCG x*69069+1 applied once, twice and three times
    localparam logic [31:0] LCG_A1 = 32'd69069;
    localparam logic [31:0] LCG_A2 = 32'd475559465;
    localparam logic [31:0] LCG_A3 = 32'd2801775573;
    localparam logic [31:0] LCG_C1 = 32'd1;
    localparam logic [31:0] LCG_C2 = 32'd69070;
    localparam logic [31:0] LCG_C3 = 32'd475628535;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } rng_t;

    typedef struct packed {
        logic tick_start;
        logic gap_dec;
        logic zero_width;
        logic pop_start;
        logic div_step;
        logic div_done;
        logic ramp;
        logic rng_step;
        logic norm_init;
        logic norm_shift;
        logic log_sq;
        logic log_mul;
        logic gap_mul;
        logic set_draw;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic [1:0] phase;
        logic       gap_zero;
        logic       width_zero;
        logic       mg_zero;
        logic       norm_done;
        logic       ramp_end;
    } sts_t;

    function automatic rng_t taus_step(rng_t s);
        rng_t        n;
        logic [31:0] t;
        t   = ((s.a << 13) ^ s.a) >> 19;
        n.a = ((s.a & 32'hFFFF_FFFE) << 12) ^ t;
        t   = ((s.b << 2) ^ s.b) >> 25;
        n.b = ((s.b & 32'hFFFF_FFF8) << 4) ^ t;
        t   = ((s.c << 3) ^ s.c) >> 11;
        n.c = ((s.c & 32'hFFFF_FFF0) << 17) ^ t;
        return n;
    endfunction

    function automatic rng_t expand_seed(logic [31:0] s);
        rng_t r;
        r.a = s * LCG_A1 + LCG_C1;
        r.b = s * LCG_A2 + LCG_C2;
        r.c = s * LCG_A3 + LCG_C3;
        if (r.a < 32'd2)
        begin
            r.a = r.a + 32'd2;
        end
        if (r.b < 32'd8)
        begin
            r.b = r.b + 32'd8;
        end
        if (r.c < 32'd16)
        begin
            r.c = r.c + 32'd16;
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/triangular_dust_noise_generator.sv
// Top level of the triangular dust noise generator.
// Depends on tdng_pkg, tdng_ctrl and tdng_dp.
//
// Popcorn noise source: each transaction on s_axis carries a tick bit and yields
// exactly one sample transaction on m_axis. A tick of 1 advances the noise by one
// sample, a tick of 0 repeats the last sample and pop flag. Between pops the output
// sits at zero for a random gap of about mean_gap samples (exponential, Taus88),
// then a triangular pop ramps to a random peak over pop_width samples and back to
// zero over pop_width samples. A pop start runs the restoring divider, one quotient
// bit per cycle, and then a state that loads the ramp step; a draw of gap and peak
// runs one-bit-per-cycle normalization and the 24 serial squarings of the log unit
// (both skipped when mean_gap is 0). A new tick is taken while the previous sample
// still waits on m_axis. Config writes on cfg_* are always ready and take effect at
// once; a seed write re-expands the generator words.
module triangular_dust_noise_generator #(
    parameter int SAMPLE_BITS = 24,
    parameter int WIDTH_BITS  = 16,
    parameter int GAP_BITS    = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,   // [0] tick
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,   // sample, then zero fill
    output logic                             m_axis_tuser,   // [0] in_pop
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [1:0]                       cfg_index,
    input  logic [31:0]                      cfg_data
);

    localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8;

    tdng_pkg::cmd_t         cmd;
    tdng_pkg::sts_t         sts;
    logic [SAMPLE_BITS-1:0] level;
    logic                   level_pop;

    // register file never stalls
    assign cfg_ready = 1'b1;

    tdng_ctrl #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .WIDTH_BITS  (WIDTH_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_tick   (s_axis_tdata[0]),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    tdng_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .WIDTH_BITS  (WIDTH_BITS),
        .GAP_BITS    (GAP_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid),
        .cfg_idx   (cfg_index),
        .cfg_wdata (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .level     (level),
        .level_pop (level_pop)
    );

    // level register doubles as the output register; it only loads when the slot is free
    assign m_axis_tdata = OUT_W'(level);
    assign m_axis_tuser = level_pop;

endmodule

FILE: hw/rtl/tdng_ctrl.sv
// Sequencer of the triangular dust noise generator.
// Depends on tdng_pkg; drives tdng_dp through cmd_t and reads sts_t.
module tdng_ctrl #(
    parameter int SAMPLE_BITS = 24,
    parameter int WIDTH_BITS  = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_tick,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  tdng_pkg::sts_t sts,
    output tdng_pkg::cmd_t cmd
);

    localparam int DIV_N = SAMPLE_BITS + WIDTH_BITS;
    localparam int CNT_N = (DIV_N > tdng_pkg::LOG_FRAC) ? DIV_N : tdng_pkg::LOG_FRAC;
    localparam int CNT_W = $clog2(CNT_N);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_GAP  = 4'd1;
    localparam logic [3:0] S_DIV  = 4'd2;
    localparam logic [3:0] S_DIVD = 4'd3;
    localparam logic [3:0] S_RAMP = 4'd4;
    localparam logic [3:0] S_DRAW = 4'd5;
    localparam logic [3:0] S_NI   = 4'd6;
    localparam logic [3:0] S_NORM = 4'd7;
    localparam logic [3:0] S_SQ   = 4'd8;
    localparam logic [3:0] S_LMUL = 4'd9;
    localparam logic [3:0] S_GMUL = 4'd10;
    localparam logic [3:0] S_PK   = 4'd11;
    localparam logic [3:0] S_SET  = 4'd12;
    localparam logic [3:0] S_FIN  = 4'd13;

    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_N - 1);
    localparam logic [CNT_W-1:0] SQ_LAST  = CNT_W'(tdng_pkg::LOG_FRAC - 1);

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ret_reg, ret_next;   // 1: after draw go on to the gap check
    logic             out_valid_reg, out_valid_next;
    logic             ramping;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign ramping   = (sts.phase == tdng_pkg::PH_UP) || (sts.phase == tdng_pkg::PH_DOWN);

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ret_next       = ret_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_tick)
                    begin
                        cmd.tick_start = 1'b1;
                        if (sts.phase == tdng_pkg::PH_DRAW)
                        begin
                            ret_next   = 1'b1;
                            state_next = S_DRAW;
                        end
                        else
                        begin
                            state_next = S_GAP;
                        end
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_GAP:
            begin
                if (sts.phase == tdng_pkg::PH_GAP)
                begin
                    if (!sts.gap_zero)
                    begin
                        cmd.gap_dec = 1'b1;
                        state_next  = S_RAMP;
                    end
                    else if (sts.width_zero)
                    begin
                        cmd.zero_width = 1'b1;
                        ret_next       = 1'b0;
                        state_next     = S_DRAW;
                    end
                    else
                    begin
                        cmd.pop_start = 1'b1;
                        cnt_next      = '0;
                        state_next    = S_DIV;
                    end
                end
                else
                begin
                    state_next = S_RAMP;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = S_DIVD;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DIVD:
            begin
                cmd.div_done = 1'b1;
                state_next   = S_RAMP;
            end
            S_RAMP:
            begin
                state_next = S_FIN;
                if (ramping)
                begin
                    cmd.ramp = 1'b1;
                    if (sts.ramp_end)
                    begin
                        ret_next   = 1'b0;
                        state_next = S_DRAW;
                    end
                end
            end
            S_DRAW:
            begin
                if (sts.mg_zero)
                begin
                    state_next = S_PK;
                end
                else
                begin
                    cmd.rng_step = 1'b1;
                    state_next   = S_NI;
                end
            end
            S_NI:
            begin
                cmd.norm_init = 1'b1;
                state_next    = S_NORM;
            end
            S_NORM:
            begin
                if (sts.norm_done)
                begin
                    cnt_next   = '0;
                    state_next = S_SQ;
                end
                else
                begin
                    cmd.norm_shift = 1'b1;
                end
            end
            S_SQ:
            begin
                cmd.log_sq = 1'b1;
                if (cnt_reg == SQ_LAST)
                begin
                    state_next = S_LMUL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_LMUL:
            begin
                cmd.log_mul = 1'b1;
                state_next  = S_GMUL;
            end
            S_GMUL:
            begin
                cmd.gap_mul = 1'b1;
                state_next  = S_PK;
            end
            S_PK:
            begin
                cmd.rng_step = 1'b1;
                state_next   = S_SET;
            end
            S_SET:
            begin
                cmd.set_draw = 1'b1;
                state_next   = ret_reg ? S_GAP : S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            ret_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ret_reg       <= ret_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: hw/rtl/tdng_dp.sv
// Datapath of the triangular dust noise generator: registers, Taus88,
// log unit, divider and ramp accumulator. Depends on tdng_pkg.
module tdng_dp #(
    parameter int SAMPLE_BITS = 24,
    parameter int WIDTH_BITS  = 16,
    parameter int GAP_BITS    = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_idx,
    input  logic [31:0]            cfg_wdata,
    input  tdng_pkg::cmd_t         cmd,
    output tdng_pkg::sts_t         sts,
    output logic [SAMPLE_BITS-1:0] level,
    output logic                   level_pop
);

    localparam int DIV_N = SAMPLE_BITS + WIDTH_BITS;
    localparam int AW    = SAMPLE_BITS + WIDTH_BITS + 1;
    localparam int SH    = 33 - SAMPLE_BITS;
    localparam int G_W   = 31;

    logic [23:0]            mean_gap_reg;
    logic [WIDTH_BITS-1:0]  pop_width_reg;
    logic [1:0]             symmetry_reg;
    tdng_pkg::rng_t         rng_reg, rng_next;
    logic [32:0]            m_reg;
    logic [31:0]            x_reg;
    logic [5:0]             lint_reg;
    logic [23:0]            frac_reg;
    logic [29:0]            neg_reg;
    logic [53:0]            prod_reg;
    logic [GAP_BITS-1:0]    gap_reg;
    logic signed [SAMPLE_BITS-1:0] peak_reg;
    logic [WIDTH_BITS-1:0]  lw_reg;
    logic [DIV_N-1:0]       num_reg;
    logic [WIDTH_BITS:0]    rem_reg;
    logic signed [AW-1:0]   step_reg;
    logic signed [AW-1:0]   accum_reg;
    logic [WIDTH_BITS-1:0]  pcount_reg;
    logic [1:0]             phase_reg;
    logic                   pop_reg;
    logic [SAMPLE_BITS-1:0] level_reg;
    logic                   last_pop_reg;

    // log unit
    logic [63:0] sq;
    logic [32:0] sq_sh;
    logic [29:0] l_val;
    logic [61:0] ln_sum;
    logic [53:0] prod;

    // gap and peak
    logic [54:0]         g_sum;
    logic [G_W-1:0]      g_val, g_sub, g_hi;
    logic [GAP_BITS-1:0] gap_val;
    logic [33:0]         m_sum;
    logic [SAMPLE_BITS:0] code;
    logic signed [SAMPLE_BITS+1:0] code_s, full_s, v;

    // divider, ramp, rounding
    logic [SAMPLE_BITS-1:0] peak_mag;
    logic [WIDTH_BITS:0]    rsh;
    logic                   qbit;
    logic signed [AW-1:0]   quo;
    logic [WIDTH_BITS:0]    cplus;
    logic                   cdone;
    logic [AW-1:0]          amag, rsum;
    logic [SAMPLE_BITS-1:0] rnd;

    assign rng_next = tdng_pkg::taus_step(rng_reg);

    assign sq     = x_reg * x_reg;
    assign sq_sh  = sq[63:31];
    assign l_val  = {lint_reg, 24'd0} - {6'd0, frac_reg};
    assign ln_sum = l_val * tdng_pkg::LN2_Q32 + 62'(64'd1 << 31);
    assign prod   = mean_gap_reg * neg_reg;

    always_comb
    begin
        g_sum   = {1'b0, prod_reg} + 55'(1 << (tdng_pkg::LOG_FRAC - 1));
        g_val   = mean_gap_reg == '0 ? '0 : g_sum[54:24];
        g_sub   = (g_val > G_W'(pop_width_reg)) ? g_val - G_W'(pop_width_reg) : '0;
        g_hi    = g_sub >> GAP_BITS;
        gap_val = (g_hi != '0) ? '1 : GAP_BITS'(g_sub);
    end

    always_comb
    begin
        m_sum  = {1'b0, m_reg} + 34'((64'd1 << SH) - 1);
        code   = m_sum[33:SH];
        code_s = signed'({1'b0, code});
        full_s = (SAMPLE_BITS+2)'(1) <<< (SAMPLE_BITS - 1);
        case (symmetry_reg)
            tdng_pkg::SYM_NEG:
            begin
                v = -code_s;
            end
            tdng_pkg::SYM_BOTH:
            begin
                v = (code_s <<< 1) - full_s;
                if (v == '0)
                begin
                    v = -full_s;
                end
            end
            default:
            begin
                v = code_s;
            end
        endcase
        if (v > full_s - 1)
        begin
            v = full_s - 1;   // +1.0 saturates
        end
    end

    always_comb
    begin
        peak_mag = peak_reg[SAMPLE_BITS-1] ? SAMPLE_BITS'(-peak_reg) : peak_reg;
        rsh      = {rem_reg[WIDTH_BITS-1:0], num_reg[DIV_N-1]};
        qbit     = (rsh >= {1'b0, lw_reg});
        quo      = signed'({1'b0, num_reg});
        cplus    = {1'b0, pcount_reg} + 1'b1;
        cdone    = (cplus >= {1'b0, lw_reg});
        amag     = accum_reg[AW-1] ? AW'(-accum_reg) : accum_reg;
        rsum     = amag + AW'(1 << (WIDTH_BITS - 1));
        rnd      = rsum[SAMPLE_BITS+WIDTH_BITS-1:WIDTH_BITS];
    end

    assign sts.phase      = phase_reg;
    assign sts.gap_zero   = (gap_reg == '0);
    assign sts.width_zero = (pop_width_reg == '0);
    assign sts.mg_zero    = (mean_gap_reg == '0);
    assign sts.norm_done  = x_reg[31];
    assign sts.ramp_end   = (phase_reg == tdng_pkg::PH_DOWN) && cdone;

    assign level     = level_reg;
    assign level_pop = last_pop_reg;

    // configuration and generator words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_gap_reg  <= tdng_pkg::MEAN_GAP_RESET;
            pop_width_reg <= WIDTH_BITS'(1);
            symmetry_reg  <= tdng_pkg::SYM_RESET;
            rng_reg       <= tdng_pkg::expand_seed(tdng_pkg::SEED_RESET);
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    tdng_pkg::CFG_MEAN_GAP:  mean_gap_reg  <= cfg_wdata[23:0];
                    tdng_pkg::CFG_POP_WIDTH: pop_width_reg <= cfg_wdata[WIDTH_BITS-1:0];
                    tdng_pkg::CFG_SYMMETRY:  symmetry_reg  <= cfg_wdata[1:0];
                    tdng_pkg::CFG_SEED:      rng_reg <= tdng_pkg::expand_seed(cfg_wdata);
                    default:                 symmetry_reg  <= symmetry_reg;
                endcase
            end
            else if (cmd.rng_step)
            begin
                rng_reg <= rng_next;
            end
        end
    end

    // draw and divider scratch registers
    always_ff @(posedge clk)
    begin
        if (cmd.rng_step)
        begin
            m_reg <= {1'b0, rng_next.a ^ rng_next.b ^ rng_next.c} + 33'd1;
        end
        if (cmd.norm_init)
        begin
            x_reg    <= m_reg[32] ? 32'h8000_0000 : m_reg[31:0];
            lint_reg <= m_reg[32] ? 6'd0 : 6'd1;
            frac_reg <= '0;
        end
        else if (cmd.norm_shift)
        begin
            x_reg    <= x_reg << 1;
            lint_reg <= lint_reg + 6'd1;
        end
        else if (cmd.log_sq)
        begin
            x_reg    <= sq_sh[32] ? sq_sh[32:1] : sq_sh[31:0];
            frac_reg <= {frac_reg[22:0], sq_sh[32]};
        end
        if (cmd.log_mul)
        begin
            neg_reg <= ln_sum[61:32];
        end
        if (cmd.gap_mul)
        begin
            prod_reg <= prod;
        end
        if (cmd.pop_start)
        begin
            num_reg <= {peak_mag, WIDTH_BITS'(0)};
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= qbit ? rsh - {1'b0, lw_reg} : rsh;
            num_reg <= {num_reg[DIV_N-2:0], qbit};
        end
        if (cmd.div_done)
        begin
            step_reg <= peak_reg[SAMPLE_BITS-1] ? -quo : quo;
        end
    end

    // noise state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg      <= '0;
            peak_reg     <= '0;
            lw_reg       <= '0;
            accum_reg    <= '0;
            pcount_reg   <= '0;
            phase_reg    <= tdng_pkg::PH_DRAW;
            pop_reg      <= 1'b0;
            level_reg    <= '0;
            last_pop_reg <= 1'b0;
        end
        else
        begin
            if (cmd.tick_start)
            begin
                pop_reg <= 1'b0;
            end
            if (cmd.gap_dec)
            begin
                gap_reg   <= gap_reg - 1'b1;
                accum_reg <= '0;
            end
            if (cmd.zero_width)
            begin
                lw_reg    <= pop_width_reg;
                accum_reg <= '0;
            end
            if (cmd.pop_start)
            begin
                lw_reg     <= pop_width_reg;
                accum_reg  <= '0;
                pcount_reg <= '0;
            end
            if (cmd.div_done)
            begin
                phase_reg <= tdng_pkg::PH_UP;
            end
            if (cmd.ramp)
            begin
                pop_reg <= 1'b1;
                if (cdone)
                begin
                    pcount_reg <= '0;
                    if (phase_reg == tdng_pkg::PH_UP)
                    begin
                        accum_reg <= AW'(peak_reg) <<< WIDTH_BITS;
                        phase_reg <= tdng_pkg::PH_DOWN;
                    end
                    else
                    begin
                        accum_reg <= '0;
                        phase_reg <= tdng_pkg::PH_GAP;
                    end
                end
                else
                begin
                    pcount_reg <= cplus[WIDTH_BITS-1:0];
                    if (phase_reg == tdng_pkg::PH_UP)
                    begin
                        accum_reg <= accum_reg + step_reg;
                    end
                    else
                    begin
                        accum_reg <= accum_reg - step_reg;
                    end
                end
            end
            if (cmd.set_draw)
            begin
                gap_reg   <= gap_val;
                peak_reg  <= v[SAMPLE_BITS-1:0];
                phase_reg <= tdng_pkg::PH_GAP;
            end
            if (cmd.finish)
            begin
                level_reg    <= accum_reg[AW-1] ? -rnd : rnd;
                last_pop_reg <= pop_reg;
            end
        end
    end

endmodule

FILE: hw/rtl/tdng_checker.sv
// Port-level checker for the triangular dust noise generator, bound to the top.
// Depends on triangular_dust_noise_generator_assert.svh.
`include "triangular_dust_noise_generator_assert.svh"

module tdng_checker #(
    parameter int SAMPLE_BITS = 24,
    parameter int OUT_W       = 24
) (
    input logic             clk,
    input logic             rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata,
    input logic             m_axis_tuser
);

    `TDNG_ASSERT_NXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `TDNG_ASSERT_NXT(a_out_stable, clk, rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
    `TDNG_ASSERT_IMP(a_quiet_zero, clk, rst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[SAMPLE_BITS-1:0] == '0)
    `TDNG_ASSERT_NXT(a_busy_after_accept, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind triangular_dust_noise_generator tdng_checker #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .OUT_W       (((SAMPLE_BITS + 7) / 8) * 8)
) u_tdng_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: bench/triangular_dust_noise_generator_tb.sv
// Self-checking bench for the triangular dust noise generator.
// Depends on tdng_pkg and the triangular_dust_noise_generator RTL; stands alone.
`timescale 1ns / 100ps

module triangular_dust_noise_generator_tb;

    localparam int SB = 24;
    localparam int WB = 16;
    localparam longint CYCLE_LIMIT = 64'd3000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;     // [0] tick
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;            // [23:0] sample
    logic        m_axis_tuser;            // [0] in_pop
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [31:0] cfg_data = 32'd0;

    triangular_dust_noise_generator u_top (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    typedef struct packed {
        logic [23:0] sample;
        logic        in_pop;
    } noise_out_t;

    // expected samples, oldest first
    noise_out_t sample_queue[$];

    // shadow of the block's registers and state
    logic [23:0] mg_reg;
    logic [15:0] width_reg;
    logic [1:0]  sym_reg;
    logic [31:0] seed_reg;
    tdng_pkg::rng_t taus;
    longint      lvl, step_q, pk, acc;
    longint unsigned gap_cnt;
    logic [1:0]  ph;
    int unsigned ph_cnt, held_width;
    bit          pop_flag;

    int errors = 0;
    int checked = 0;
    int pops_seen = 0;
    longint cycles = 0;
    int send_idle = 0;
    int recv_idle = 0;

    function automatic logic [31:0] lcg(logic [31:0] x);
        return x * 32'd69069 + 32'd1;
    endfunction

    task automatic reseed();
        logic [31:0] x;
        x = lcg(seed_reg);
        taus.a = x;
        x = lcg(x);
        taus.b = x;
        x = lcg(x);
        taus.c = x;
        if (taus.a < 2) taus.a += 2;
        if (taus.b < 8) taus.b += 8;
        if (taus.c < 16) taus.c += 16;
    endtask

    // one Taus88 step, returns r+1 in 1..2^32
    task automatic next_unit(output longint unsigned m);
        logic [31:0] a, b, c, t;
        a = taus.a;
        b = taus.b;
        c = taus.c;
        t = ((a << 13) ^ a) >> 19;
        a = ((a & 32'hFFFF_FFFE) << 12) ^ t;
        t = ((b << 2) ^ b) >> 25;
        b = ((b & 32'hFFFF_FFF8) << 4) ^ t;
        t = ((c << 3) ^ c) >> 11;
        c = ((c & 32'hFFFF_FFF0) << 17) ^ t;
        taus.a = a;
        taus.b = b;
        taus.c = c;
        m = {32'd0, a ^ b ^ c} + 64'd1;
    endtask

    // -ln(m/2^32) with 24 fraction bits
    function automatic longint unsigned minus_ln(longint unsigned m);
        int unsigned k, i;
        longint unsigned x, frac, l;
        k = 0;
        frac = 0;
        while (k < 40 && (m >> (k + 1)) != 0) k++;
        x = (k <= 31) ? (m << (31 - k)) : (m >> (k - 31));
        for (i = 0; i < 24; i++)
        begin
            x = (x * x) >> 31;
            frac = frac << 1;
            if (x >= (64'd1 << 32))
            begin
                frac |= 1;
                x = x >> 1;
            end
        end
        l = (k >= 32) ? 0 : (((64'(32 - k)) << 24) - frac);
        return (l * 64'd2977044472 + (64'd1 << 31)) >> 32;
    endfunction

    task automatic draw_gap_peak();
        longint unsigned g, m, code;
        longint v;
        g = 0;
        if (mg_reg != 0)
        begin
            next_unit(m);
            g = (64'(mg_reg) * minus_ln(m) + (64'd1 << 23)) >> 24;
        end
        g = (g > width_reg) ? g - width_reg : 0;
        gap_cnt = (g > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : g;
        next_unit(m);
        code = (m + ((64'd1 << (33 - SB)) - 1)) >> (33 - SB);
        if (sym_reg == tdng_pkg::SYM_NEG) v = -longint'(code);
        else if (sym_reg == tdng_pkg::SYM_BOTH)
        begin
            v = 2 * longint'(code) - (64'sd1 <<< (SB - 1));
            if (v == 0) v = -(64'sd1 <<< (SB - 1));
        end
        else v = longint'(code);
        if (v > (64'sd1 <<< (SB - 1)) - 1) v = (64'sd1 <<< (SB - 1)) - 1;
        pk = v;
    endtask

    task automatic noise_reset();
        mg_reg = tdng_pkg::MEAN_GAP_RESET;
        width_reg = 16'd1;
        sym_reg = tdng_pkg::SYM_RESET;
        seed_reg = tdng_pkg::SEED_RESET;
        reseed();
        lvl = 0; step_q = 0; pk = 0; acc = 0; gap_cnt = 0;
        ph = tdng_pkg::PH_DRAW; ph_cnt = 0; held_width = 0; pop_flag = 0;
    endtask

    // advance the shadow by one transaction and queue the sample it yields
    task automatic predict_noise(logic tick);
        longint unsigned mag, r;
        longint q;
        noise_out_t e;
        bit pop;
        if (tick)
        begin
            pop = 0;
            if (ph == tdng_pkg::PH_DRAW)
            begin
                draw_gap_peak();
                ph = tdng_pkg::PH_GAP;
            end
            if (ph == tdng_pkg::PH_GAP)
            begin
                if (gap_cnt > 0)
                begin
                    gap_cnt--;
                    acc = 0;
                end
                else
                begin
                    held_width = width_reg;
                    acc = 0;
                    if (held_width == 0) draw_gap_peak();   // silent pop
                    else
                    begin
                        mag = (pk < 0) ? -pk : pk;
                        q = longint'((mag << WB) / held_width);
                        step_q = (pk < 0) ? -q : q;
                        ph_cnt = 0;
                        ph = tdng_pkg::PH_UP;
                    end
                end
            end
            if (ph == tdng_pkg::PH_UP)
            begin
                pop = 1;
                ph_cnt++;
                if (ph_cnt >= held_width)
                begin
                    acc = pk * (64'sd1 <<< WB);   // top lands exactly on the peak
                    ph = tdng_pkg::PH_DOWN;
                    ph_cnt = 0;
                end
                else acc += step_q;
            end
            else if (ph == tdng_pkg::PH_DOWN)
            begin
                pop = 1;
                ph_cnt++;
                if (ph_cnt >= held_width)
                begin
                    acc = 0;
                    ph_cnt = 0;
                    draw_gap_peak();
                    ph = tdng_pkg::PH_GAP;
                    pops_seen++;
                end
                else acc -= step_q;
            end
            mag = (acc < 0) ? -acc : acc;
            r = (mag + (64'd1 << (WB - 1))) >> WB;
            lvl = (acc < 0) ? -longint'(r) : longint'(r);
            pop_flag = pop;
        end
        e.sample = lvl[23:0];
        e.in_pop = pop_flag;
        sample_queue.push_back(e);
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("mismatch %0s: got %0d expected %0d (result %0d)", what, got, want, checked);
    endtask

    // output monitor and checker
    always @(posedge clk)
    begin
        noise_out_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (sample_queue.size() == 0) report_mismatch("unexpected sample", 0, 0);
            else
            begin
                e = sample_queue.pop_front();
                if (m_axis_tdata !== e.sample)
                    report_mismatch("sample", $signed(m_axis_tdata), $signed(e.sample));
                if (m_axis_tuser !== e.in_pop)
                    report_mismatch("in_pop", m_axis_tuser, e.in_pop);
            end
            checked++;
        end
    end

    // receiver back-pressure, changed at the falling edge
    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("triangular_dust_noise_generator_tb: FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            tdng_pkg::CFG_MEAN_GAP:  mg_reg = val[23:0];
            tdng_pkg::CFG_POP_WIDTH: width_reg = val[15:0];
            tdng_pkg::CFG_SYMMETRY:  sym_reg = val[1:0];
            default:
            begin
                seed_reg = val;
                reseed();
            end
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // wait for the queue to drain, then let a draw or divide finish
    task automatic drain();
        while (sample_queue.size() != 0) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    // one tick transaction, with a random idle gap beforehand
    task automatic send_tick(logic tick);
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, tick};
        do @(posedge clk); while (!s_axis_tready);
        predict_noise(tick);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
    endtask

    // directed rows: cfg write or tick; every tick is checked against the shadow model
    typedef struct {
        bit          is_cfg;
        logic [1:0]  idx;
        logic [31:0] val;
    } step_row_t;

    step_row_t rows[$];

    initial
    begin
        int i, n, p;
        noise_reset();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // tick low after reset: zero, not in a pop
        send_tick(1'b0);
        drain();
        if (checked != 1) report_mismatch("reset sample count", checked, 1);

        rows = '{
            '{1, tdng_pkg::CFG_MEAN_GAP, 32'd0}, '{1, tdng_pkg::CFG_POP_WIDTH, 32'd3},
            '{0, 0, 1}, '{0, 0, 1}, '{0, 0, 0}, '{0, 0, 1}, '{0, 0, 1}, '{0, 0, 1},
            '{1, tdng_pkg::CFG_SYMMETRY, 32'd1}, '{0, 0, 1}, '{0, 0, 1}, '{0, 0, 1},
            '{1, tdng_pkg::CFG_SYMMETRY, 32'd2}, '{0, 0, 1}, '{0, 0, 1}, '{0, 0, 1},
            '{1, tdng_pkg::CFG_SYMMETRY, 32'd3}, '{1, tdng_pkg::CFG_POP_WIDTH, 32'd0},
            '{0, 0, 1}, '{0, 0, 1},
            '{1, tdng_pkg::CFG_POP_WIDTH, 32'd65535}, '{0, 0, 1},
            '{1, tdng_pkg::CFG_POP_WIDTH, 32'd1},
            '{0, 0, 1}, '{1, tdng_pkg::CFG_SEED, 32'hFFFF_FFFF},
            '{1, tdng_pkg::CFG_MEAN_GAP, 32'hFF_FFFF},
            '{0, 0, 1}, '{0, 0, 1}, '{1, tdng_pkg::CFG_SEED, 32'd0},
            '{1, tdng_pkg::CFG_MEAN_GAP, 32'd5},
            '{0, 0, 1}, '{0, 0, 1}, '{0, 0, 0}
        };
        foreach (rows[i])
        begin
            if (rows[i].is_cfg)
            begin
                drain();
                write_reg(rows[i].idx, rows[i].val);
            end
            else send_tick(rows[i].val[0]);
        end
        drain();

        // random phases: three idle mixes, each with three random settings
        for (p = 0; p < 3; p++)
        begin
            send_idle = (p == 0) ? 32 : (p == 1) ? 47 : 0;
            recv_idle = (p == 0) ? 47 : (p == 1) ? 32 : 0;
            for (n = 0; n < 3; n++)
            begin
                drain();
                write_reg(tdng_pkg::CFG_MEAN_GAP, $urandom_range(40));
                write_reg(tdng_pkg::CFG_POP_WIDTH,
                          ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12));
                write_reg(tdng_pkg::CFG_SYMMETRY, $urandom_range(3));
                write_reg(tdng_pkg::CFG_SEED, $urandom);
                for (i = 0; i < 110; i++)
                begin
                    send_tick($urandom_range(9) != 0);
                    // hold the sender until everything has come back
                    if (i == 50)
                        while (sample_queue.size() != 0) @(posedge clk);
                end
            end
        end

        while (sample_queue.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        $display("covered %0d samples, %0d complete pops, all registers and idle mixes",
                 checked, pops_seen);
        if (errors == 0 && sample_queue.size() == 0)
            $display("triangular_dust_noise_generator_tb: PASS");
        else
            $display("triangular_dust_noise_generator_tb: FAIL");
        $finish;
    end

endmodule
